// ===== hw/rtl/greedy_nearest_segment_router_defines.svh =====
// Assertion helpers for the segment router. They are compiled out when SYNTHESIS is defined.
// Both helpers sample on clk and are disabled while rst_n is low.
// GNSR_ASSERT_SAME: the consequent must hold in the same cycle as the antecedent.
// GNSR_ASSERT_NEXT: the consequent must hold one cycle after the antecedent.
`ifndef GREEDY_NEAREST_SEGMENT_ROUTER_DEFINES_SVH
`define GREEDY_NEAREST_SEGMENT_ROUTER_DEFINES_SVH
`ifndef SYNTHESIS
`define GNSR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GNSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GNSR_ASSERT_SAME(label, ante, cons, msg)
`define GNSR_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/gnsr_pkg.sv =====
package gnsr_pkg;

    localparam int OUT_COORD_W = 16;
    localparam int OUT_INDEX_W = 12;
    localparam int IN_COORD_W  = 16;

    // Drain count from the last scan issue until the running best is final:
    // covers the registered memory read plus three stages of the distance unit.
    localparam int DRAIN_CYCLES = 4;
    localparam int DRAIN_W      = 3;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_NEXT  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [IN_COORD_W-1:0] point_a_x;
        logic [IN_COORD_W-1:0] point_a_y;
        logic [IN_COORD_W-1:0] point_b_x;
        logic [IN_COORD_W-1:0] point_b_y;
    } cmd_t;

    typedef struct packed {
        logic [OUT_COORD_W-1:0] from_x;
        logic [OUT_COORD_W-1:0] from_y;
        logic [OUT_COORD_W-1:0] to_x;
        logic [OUT_COORD_W-1:0] to_y;
        logic [OUT_INDEX_W-1:0] chosen_index;
        logic                   exhausted;
    } res_t;

    typedef struct packed {
        logic seg_we;
        logic vis_we;
        logic vis_val;
    } wr_ctl_t;

endpackage

// ===== hw/rtl/gnsr_store.sv =====
module gnsr_store #(
    parameter int DEPTH = 4096,
    parameter int IDX_W = 12,
    parameter int SEG_W = 64
) (
    input  logic              clk,
    input  gnsr_pkg::wr_ctl_t wr_ctl,
    input  logic [IDX_W-1:0]  waddr,
    input  logic [SEG_W-1:0]  wdata,
    input  logic [IDX_W-1:0]  raddr,
    output logic [SEG_W-1:0]  rdata,
    output logic              rvisited
);
    import gnsr_pkg::*;

    logic [SEG_W-1:0] seg_mem [DEPTH];
    logic             vis_mem [DEPTH];

    // Write segment and visited mark; both share the address.
    always_ff @(posedge clk)
    begin
        if (wr_ctl.seg_we)
        begin
            seg_mem[waddr] <= wdata;
        end
        if (wr_ctl.vis_we)
        begin
            vis_mem[waddr] <= wr_ctl.vis_val;
        end
    end

    // Registered read.
    always_ff @(posedge clk)
    begin
        rdata    <= seg_mem[raddr];
        rvisited <= vis_mem[raddr];
    end

endmodule

// ===== hw/rtl/gnsr_dist.sv =====
module gnsr_dist #(
    parameter int CB    = 16,
    parameter int TAG_W = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [CB-1:0]    px,
    input  logic [CB-1:0]    py,
    input  logic [CB-1:0]    qx,
    input  logic [CB-1:0]    qy,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [2*CB:0]    out_dist,
    output logic [TAG_W-1:0] out_tag
);
    import gnsr_pkg::*;

    logic             v1_reg, v2_reg, v3_reg;
    logic [CB-1:0]    dx_reg, dy_reg;
    logic [2*CB-1:0]  sqx_reg, sqy_reg;
    logic [2*CB:0]    sum_reg;
    logic [TAG_W-1:0] t1_reg, t2_reg, t3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage 1 absolute differences, stage 2 squares, stage 3 sum.
    always_ff @(posedge clk)
    begin
        dx_reg  <= (px >= qx) ? (px - qx) : (qx - px);
        dy_reg  <= (py >= qy) ? (py - qy) : (qy - py);
        t1_reg  <= in_tag;
        sqx_reg <= dx_reg * dx_reg;
        sqy_reg <= dy_reg * dy_reg;
        t2_reg  <= t1_reg;
        sum_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
        t3_reg  <= t2_reg;
    end

    assign out_valid = v3_reg;
    assign out_dist  = sum_reg;
    assign out_tag   = t3_reg;

endmodule

// ===== hw/rtl/greedy_nearest_segment_router.sv =====
// Channel  Direction  Payload            Accepted when
// cmd      in         gnsr_pkg::cmd_t    cmd_valid && !cmd_stall
// res      out        gnsr_pkg::res_t    res_valid && !res_stall
//
// Clear, load and unused kinds are accepted in idle and start no scan.
// During a next request every unvisited stored segment passes the shared distance
// unit twice, once per endpoint, one endpoint a cycle.
// Reset (rst_n, async, active low) empties the table; no clearing pass is needed.
// cmd_stall is high while a next request is being worked on; a finished beat
// waits in the result register and holds the sequencer only if still unread.
`include "greedy_nearest_segment_router_defines.svh"

module greedy_nearest_segment_router #(
    parameter int MAX_SEGMENTS = 4096,
    parameter int COORD_BITS   = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  gnsr_pkg::cmd_t cmd,
    output logic           res_valid,
    input  logic           res_stall,
    output gnsr_pkg::res_t res
);
    import gnsr_pkg::*;

    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int SEG_W = 4 * COORD_BITS;
    localparam int DW    = 2 * COORD_BITS + 1;
    localparam int TAG_W = IDX_W + 1;

    // Sequencer.
    state_t state_reg, state_next;

    // Walk state.
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [COORD_BITS-1:0] pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0] pos_y_reg, pos_y_next;
    logic [IDX_W-1:0]      start_reg, start_next;

    // Scan state.
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [IDX_W-1:0]      addr_reg, addr_next;
    logic                  phase_reg, phase_next;
    logic [DRAIN_W-1:0]    drain_reg, drain_next;
    logic                  tag_valid_reg;
    logic                  tag_end_reg;
    logic [IDX_W-1:0]      tag_idx_reg;

    // Running best.
    logic                  found_reg, found_next;
    logic [DW-1:0]         best_d_reg, best_d_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic                  best_end_reg, best_end_next;

    // Result register.
    logic                  res_valid_reg, res_valid_next;
    res_t                  res_reg, res_next;

    // Sequencer outputs.
    logic                  accept;
    logic                  issue;
    logic                  scan_done;
    logic                  drain_done;
    logic                  res_free;
    logic                  commit;

    // Store and distance unit.
    wr_ctl_t               wr_ctl;
    logic [IDX_W-1:0]      waddr;
    logic [SEG_W-1:0]      wdata;
    logic [IDX_W-1:0]      raddr;
    logic [SEG_W-1:0]      rdata;
    logic                  rvisited;
    logic [COORD_BITS-1:0] r_ax, r_ay, r_bx, r_by;
    logic                  d_in_valid;
    logic [COORD_BITS-1:0] d_px, d_py;
    logic                  d_out_valid;
    logic [DW-1:0]         d_out_dist;
    logic [TAG_W-1:0]      d_out_tag;
    logic                  d_end;
    logic [IDX_W-1:0]      d_idx;
    logic                  take;
    logic [COORD_BITS-1:0] f_x, f_y, t_x, t_y;

    assign scan_done  = (cnt_reg == count_reg);
    assign drain_done = (drain_reg == DRAIN_W'(DRAIN_CYCLES - 1));
    assign res_free   = !res_valid_reg || !res_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && (cmd.kind == KIND_NEXT))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_done)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        cmd_stall = 1'b1;
        accept    = 1'b0;
        issue     = 1'b0;
        commit    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_stall = 1'b0;
                accept    = cmd_valid;
            end
            ST_SCAN:
            begin
                issue = !scan_done;
            end
            ST_FINISH:
            begin
                commit = res_free;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    // Split the read word into its endpoints.
    assign {r_ax, r_ay, r_bx, r_by} = rdata;

    // Feed one endpoint per cycle; drop visited segments here.
    assign d_in_valid = tag_valid_reg && !rvisited;
    assign d_px       = tag_end_reg ? r_bx : r_ax;
    assign d_py       = tag_end_reg ? r_by : r_ay;
    assign {d_idx, d_end} = d_out_tag;

    // A start point is taken if nothing is found yet or it beats the best so far; the end
    // point of the same segment always follows a start point that already set found.
    assign take = d_out_valid && ((!found_reg && !d_end) || (d_out_dist < best_d_reg));

    // Orient the chosen segment, nearer endpoint first.
    assign f_x = best_end_reg ? r_bx : r_ax;
    assign f_y = best_end_reg ? r_by : r_ay;
    assign t_x = best_end_reg ? r_ax : r_bx;
    assign t_y = best_end_reg ? r_ay : r_by;

    // Store ports.
    always_comb
    begin
        wr_ctl  = '0;
        waddr   = best_idx_reg;
        wdata   = {COORD_BITS'(cmd.point_a_x), COORD_BITS'(cmd.point_a_y),
                   COORD_BITS'(cmd.point_b_x), COORD_BITS'(cmd.point_b_y)};
        if (accept && (cmd.kind == KIND_LOAD) && (count_reg < CNT_W'(MAX_SEGMENTS)))
        begin
            wr_ctl.seg_we  = 1'b1;
            wr_ctl.vis_we  = 1'b1;
            wr_ctl.vis_val = 1'b0;
            waddr          = count_reg[IDX_W-1:0];
        end
        else if (commit && found_reg)
        begin
            wr_ctl.vis_we  = 1'b1;
            wr_ctl.vis_val = 1'b1;
        end
        raddr = (state_reg == ST_SCAN) ? addr_reg : best_idx_reg;
    end

    // Datapath next values.
    always_comb
    begin
        count_next     = count_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        start_next     = start_reg;
        cnt_next       = cnt_reg;
        addr_next      = addr_reg;
        phase_next     = phase_reg;
        drain_next     = drain_reg;
        found_next     = found_reg;
        best_d_next    = best_d_reg;
        best_idx_next  = best_idx_reg;
        best_end_next  = best_end_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;

        if (accept)
        begin
            unique case (cmd.kind)
                KIND_CLEAR:
                begin
                    count_next = '0;
                    pos_x_next = '0;
                    pos_y_next = '0;
                    start_next = '0;
                end
                KIND_LOAD:
                begin
                    if (count_reg < CNT_W'(MAX_SEGMENTS))
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                KIND_NEXT:
                begin
                    cnt_next   = '0;
                    addr_next  = start_reg;
                    phase_next = 1'b0;
                    drain_next = '0;
                    found_next = 1'b0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end

        // Advance the scan address after the end point of each segment, wrapping.
        if (issue)
        begin
            phase_next = !phase_reg;
            if (phase_reg)
            begin
                cnt_next  = cnt_reg + CNT_W'(1);
                addr_next = ((CNT_W'(addr_reg) + CNT_W'(1)) == count_reg) ?
                            '0 : (addr_reg + IDX_W'(1));
            end
        end

        if (state_reg == ST_DRAIN)
        begin
            drain_next = drain_reg + DRAIN_W'(1);
        end

        if (take)
        begin
            found_next    = 1'b1;
            best_d_next   = d_out_dist;
            best_idx_next = d_idx;
            best_end_next = d_end;
        end

        if (commit)
        begin
            res_valid_next = 1'b1;
            if (found_reg)
            begin
                res_next.from_x       = OUT_COORD_W'(f_x);
                res_next.from_y       = OUT_COORD_W'(f_y);
                res_next.to_x         = OUT_COORD_W'(t_x);
                res_next.to_y         = OUT_COORD_W'(t_y);
                res_next.chosen_index = OUT_INDEX_W'(best_idx_reg);
                res_next.exhausted    = 1'b0;
                pos_x_next            = t_x;
                pos_y_next            = t_y;
                start_next            = best_idx_reg;
            end
            else
            begin
                res_next           = '0;
                res_next.exhausted = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            start_reg     <= '0;
            cnt_reg       <= '0;
            addr_reg      <= '0;
            phase_reg     <= 1'b0;
            drain_reg     <= '0;
            tag_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            start_reg     <= start_next;
            cnt_reg       <= cnt_next;
            addr_reg      <= addr_next;
            phase_reg     <= phase_next;
            drain_reg     <= drain_next;
            tag_valid_reg <= issue;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers: tag tracks the read, best tracks the distance unit.
    always_ff @(posedge clk)
    begin
        tag_end_reg  <= phase_reg;
        tag_idx_reg  <= addr_reg;
        best_d_reg   <= best_d_next;
        best_idx_reg <= best_idx_next;
        best_end_reg <= best_end_next;
        res_reg      <= res_next;
    end

    gnsr_store #(
        .DEPTH (MAX_SEGMENTS),
        .IDX_W (IDX_W),
        .SEG_W (SEG_W)
    ) u_store (
        .clk      (clk),
        .wr_ctl   (wr_ctl),
        .waddr    (waddr),
        .wdata    (wdata),
        .raddr    (raddr),
        .rdata    (rdata),
        .rvisited (rvisited)
    );

    gnsr_dist #(
        .CB    (COORD_BITS),
        .TAG_W (TAG_W)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_in_valid),
        .px        (d_px),
        .py        (d_py),
        .qx        (pos_x_reg),
        .qy        (pos_y_reg),
        .in_tag    ({tag_idx_reg, tag_end_reg}),
        .out_valid (d_out_valid),
        .out_dist  (d_out_dist),
        .out_tag   (d_out_tag)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // An exhausted beat carries all-zero fields.
    `GNSR_ASSERT_SAME(a_exhausted_zero, res_valid_reg && res_reg.exhausted, (res_reg.from_x == '0) && (res_reg.from_y == '0) && (res_reg.to_x == '0) && (res_reg.to_y == '0) && (res_reg.chosen_index == '0), "exhausted beat with nonzero fields")
    // The scan start always points inside the table.
    `GNSR_ASSERT_SAME(a_start_in_table, count_reg != '0, CNT_W'(start_reg) < count_reg, "scan start outside table")
    // The far endpoint of a delivered segment becomes the position.
    `GNSR_ASSERT_NEXT(a_position_follows, commit && found_reg, (OUT_COORD_W'(pos_x_reg) == res_reg.to_x) && (OUT_COORD_W'(pos_y_reg) == res_reg.to_y), "position does not match result")

endmodule
